### hdl/lru_page_replacement_macros.svh
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shared property shorthands for the checkers of the LRU page tracker.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Widths, field positions and the types passed between the tracker's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 20;
	localparam int FRAMES_MAX    = 64;
	localparam int SLOT_W        = $clog2(FRAMES_MAX);

	localparam int PAGE_NUMBER_W = 20;
	localparam int CFG_W         = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
	localparam int STAMP_W       = 32;
	localparam int TOTAL_W       = 32;
	localparam int FRAME_USED_W  = 4;

	localparam int S_TDATA_W     = 24;
	localparam int M_TDATA_W     = 96;

	// Result field positions in the master-side tdata.
	localparam int OUT_HIT_BIT   = 0;
	localparam int OUT_FRAME_LO  = 1;
	localparam int OUT_EVICT_BIT = 5;
	localparam int OUT_PAGE_LO   = 6;
	localparam int OUT_PAGE_HI   = OUT_PAGE_LO + PAGE_NUMBER_W - 1;
	localparam int OUT_HITS_LO   = OUT_PAGE_HI + 1;
	localparam int OUT_FAULTS_LO = OUT_HITS_LO + TOTAL_W;
	localparam int OUT_USED_W    = OUT_FAULTS_LO + TOTAL_W;

	// One frame entry presented to the scan comparator.
	typedef struct packed {
		logic              start;
		logic              step;
		logic              frame_valid;
		logic [SLOT_W-1:0] idx;
	} scan_ctl_t;

	// Outcome of a full scan.
	typedef struct packed {
		logic              hit;
		logic              empty;
		logic [SLOT_W-1:0] slot;
	} scan_res_t;

endpackage

`default_nettype wire

### hdl/lru_scan.sv
// ----------------------------------------------------------------------------
// LRU frame scan unit
// Compares one frame per cycle against the requested page and tracks the
// first hit, the first empty frame and the oldest stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_scan
	import lru_pkg::*;
#(
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire scan_ctl_t            ctl,
	input  wire logic [PAGE_BITS-1:0] req_page,
	input  wire logic [PAGE_BITS-1:0] entry_page,
	input  wire logic [STAMP_W-1:0]   entry_stamp,
	output scan_res_t                 res
);

	logic              hit_q;
	logic              empty_q;
	logic              have_min_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic [SLOT_W-1:0] empty_idx_q;
	logic [SLOT_W-1:0] min_idx_q;
	logic [STAMP_W-1:0] min_stamp_q;

	logic take_hit;
	logic take_empty;
	logic take_min;

	assign take_hit   = ctl.step && ctl.frame_valid && !hit_q && (entry_page == req_page);
	assign take_empty = ctl.step && !ctl.frame_valid && !empty_q;
	assign take_min   = ctl.step && ctl.frame_valid &&
		(!have_min_q || (entry_stamp < min_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			empty_q    <= 1'b0;
			have_min_q <= 1'b0;
		end else if (ctl.start) begin
			hit_q      <= 1'b0;
			empty_q    <= 1'b0;
			have_min_q <= 1'b0;
		end else begin
			if (take_hit) begin
				hit_q <= 1'b1;
			end
			if (take_empty) begin
				empty_q <= 1'b1;
			end
			if (take_min) begin
				have_min_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q <= ctl.idx;
		end
		if (take_empty) begin
			empty_idx_q <= ctl.idx;
		end
		if (take_min) begin
			min_idx_q   <= ctl.idx;
			min_stamp_q <= entry_stamp;
		end
	end

	always_comb begin
		res.hit   = hit_q;
		res.empty = empty_q;
		if (hit_q) begin
			res.slot = hit_idx_q;
		end else if (empty_q) begin
			res.slot = empty_idx_q;
		end else begin
			res.slot = min_idx_q;
		end
	end

endmodule

`default_nettype wire

### hdl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// LRU page replacement tracker
// Fully associative page-frame tracker with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one page reference. The block walks the
// active frames with a single comparator, one frame per cycle, looking for a
// resident copy of the page, the lowest-index empty frame and the frame with
// the oldest access stamp (ties go to the lowest index). A hit refreshes the
// stamp of the matching frame; a fault fills the first empty frame or, when
// all active frames are occupied, evicts the least recently used one. One
// result request per reference leaves on the master stream. A reference
// is accepted, then the comparator walks the active frames in index order,
// a further step retires the last compare, the chosen frame's page is read
// back, and the commit applies the update and loads the output register.
// The slave side is ready only while the block is idle. The output register
// lets the next reference be taken while a result still waits; the commit
// holds until that register is free.
// frames_in_use is written through the configuration channel and should only
// change while no reference is in flight; a value of zero acts as one and a
// value above FRAMES acts as FRAMES. Frame pages and stamps live in plain
// memories without reset; per-frame valid bits clear at reset.
`default_nettype none

module lru_page_replacement
	import lru_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// Page reference requests.
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// [19:0] page_number, [23:20] zero
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,

	// Reference results.
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// [0] was_hit, [4:1] frame_used, [5] did_evict, [25:6] evicted_page,
	// [57:26] hit_total, [89:58] fault_total, [95:90] zero
	output logic [M_TDATA_W-1:0]      m_axis_tdata,

	// frames_in_use register write.
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_LAST   = 5'b00100,
		ST_FETCH  = 5'b01000,
		ST_COMMIT = 5'b10000
	} state_t;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		return (v == {TOTAL_W{1'b1}}) ? v : v + TOTAL_W'(1);
	endfunction

	state_t state_q;

	logic [CFG_W-1:0]     frames_in_use_q;
	logic [PAGE_BITS-1:0] req_page_q;
	logic [FIDX_W-1:0]    last_idx_q;
	logic [FIDX_W-1:0]    last_idx_d;
	logic [FIDX_W-1:0]    rd_cnt_q;
	logic [FIDX_W-1:0]    rd_addr;
	logic [FRAMES-1:0]    frame_valid_q;

	logic [PAGE_BITS-1:0] page_mem [FRAMES];
	logic [STAMP_W-1:0]   stamp_mem [FRAMES];
	logic [PAGE_BITS-1:0] rd_page_q;
	logic [STAMP_W-1:0]   rd_stamp_q;

	logic                 step_s1;
	logic                 fv_s1;
	logic [FIDX_W-1:0]    idx_s1;

	logic [STAMP_W-1:0]   access_clock_q;
	logic [STAMP_W-1:0]   clock_next;
	logic [TOTAL_W-1:0]   hits_q;
	logic [TOTAL_W-1:0]   faults_q;

	logic                     out_valid_q;
	logic                     out_hit_q;
	logic [FRAME_USED_W-1:0]  out_frame_q;
	logic                     out_evict_q;
	logic [PAGE_NUMBER_W-1:0] out_page_q;

	scan_ctl_t          scan_ctl;
	scan_res_t          scan_res;
	logic [FIDX_W-1:0]  slot;
	logic               s_fire;
	logic               commit_fire;
	logic               evict;
	logic [31:0]        fu_w;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign slot        = scan_res.slot[FIDX_W-1:0];
	assign evict       = !scan_res.hit && !scan_res.empty;
	assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || m_axis_tready);
	assign clock_next  = sat_inc(access_clock_q);

	// Clamp the configured count to the range 1..FRAMES and keep its last index.
	assign fu_w = 32'(frames_in_use_q);
	always_comb begin
		if (fu_w == 32'd0) begin
			last_idx_d = '0;
		end else if (fu_w > 32'(FRAMES)) begin
			last_idx_d = FIDX_W'(FRAMES - 1);
		end else begin
			last_idx_d = FIDX_W'(fu_w - 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frames_in_use_q <= cfg_data;
		end
	end

	// Sequencer: accept, walk the frames, retire the last compare, read the
	// chosen frame back, then commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_cnt_q == last_idx_q) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_page_q <= PAGE_BITS'(s_axis_tdata[PAGE_NUMBER_W-1:0]);
			last_idx_q <= last_idx_d;
			rd_cnt_q   <= '0;
		end else if (state_q == ST_SCAN && rd_cnt_q != last_idx_q) begin
			rd_cnt_q <= rd_cnt_q + FIDX_W'(1);
		end
		idx_s1 <= rd_cnt_q;
		fv_s1  <= frame_valid_q[rd_cnt_q];
	end

	// Frame memories: the page read port is driven by the walk or by the chosen slot; the stamp read port by the walk.
	assign rd_addr = (state_q == ST_SCAN) ? rd_cnt_q : slot;

	always_ff @(posedge clk) begin
		if (commit_fire && !scan_res.hit) begin
			page_mem[slot] <= req_page_q;
		end
		rd_page_q <= page_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (commit_fire) begin
			stamp_mem[slot] <= clock_next;
		end
		rd_stamp_q <= stamp_mem[rd_cnt_q];
	end

	assign scan_ctl.start       = s_fire;
	assign scan_ctl.step        = step_s1;
	assign scan_ctl.frame_valid = fv_s1;
	assign scan_ctl.idx         = SLOT_W'(idx_s1);

	lru_scan #(
		.PAGE_BITS (PAGE_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.req_page    (req_page_q),
		.entry_page  (rd_page_q),
		.entry_stamp (rd_stamp_q),
		.res         (scan_res)
	);

	// Commit: stamp, valid bit, totals and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q  <= '0;
			access_clock_q <= '0;
			hits_q         <= '0;
			faults_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (commit_fire) begin
				access_clock_q <= clock_next;
				out_valid_q    <= 1'b1;
				if (scan_res.hit) begin
					hits_q <= sat_inc(hits_q);
				end else begin
					faults_q            <= sat_inc(faults_q);
					frame_valid_q[slot] <= 1'b1;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit_fire) begin
			out_hit_q   <= scan_res.hit;
			out_frame_q <= FRAME_USED_W'(slot);
			out_evict_q <= evict;
			out_page_q  <= evict ? PAGE_NUMBER_W'(rd_page_q) : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		(M_TDATA_W - OUT_USED_W)'(0),
		faults_q,
		hits_q,
		out_page_q,
		out_evict_q,
		out_frame_q,
		out_hit_q
	};

endmodule

`default_nettype wire

### hdl/lru_checker.sv
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level assertions on the tracker's request and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_page_replacement_macros.svh"

module lru_checker
	import lru_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_axis_tvalid,
	input wire logic                 s_axis_tready,
	input wire logic                 m_axis_tvalid,
	input wire logic                 m_axis_tready,
	input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

	`LRU_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`LRU_ASSERT_NEXT(a_one_ref, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second reference taken during a walk")
	`LRU_ASSERT_IMPL(a_hit_no_evict, clk, arst_n, m_axis_tvalid, !(m_axis_tdata[OUT_HIT_BIT] && m_axis_tdata[OUT_EVICT_BIT]), "hit reported with an eviction")
	`LRU_ASSERT_IMPL(a_evict_page_zero, clk, arst_n, m_axis_tvalid && !m_axis_tdata[OUT_EVICT_BIT], m_axis_tdata[OUT_PAGE_HI:OUT_PAGE_LO] == '0, "evicted page nonzero without eviction")

endmodule

bind lru_page_replacement lru_checker u_lru_checker (.*);

`default_nettype wire
